// ----- rtl/wad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average distance sensor package
// Shared constants and types for the window cells, the serial divider and the
// distance search.
// ----------------------------------------------------------------------------
package wad_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int OUT_BITS  = 12;
  localparam int CHAN_BITS = 2;

  localparam int DIST_BITS = 11;
  localparam int DIST_A_W  = 21;
  localparam int DIST_SQ_W = 42;

  localparam logic [DIST_A_W-1:0]  DIST_SCALE = 21'd1000;
  localparam logic [DIST_A_W-1:0]  DIST_OFS   = 21'd22448;
  localparam logic [DIST_SQ_W-1:0] DIST_LIMIT = 42'd1732100 * 42'd1732100;

  typedef struct packed {
    logic shift;
    logic clear;
  } wad_cell_ctl_t;

endpackage

// ----- rtl/wad_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// Holds one stored sample of the window and adds it to the partial sum that
// travels down the row of cells.
// ----------------------------------------------------------------------------
module wad_cell
  import wad_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS_DEF + 4
) (
  input  logic                   clk,
  input  wad_cell_ctl_t          ctl,
  input  logic [SAMPLE_BITS-1:0] smp_in,
  input  logic [SUM_W-1:0]       psum_in,
  output logic [SAMPLE_BITS-1:0] smp_out,
  output logic [SUM_W-1:0]       psum_out
);

  logic [SAMPLE_BITS-1:0] smp_r;
  logic [SUM_W-1:0]       psum_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      smp_r <= ctl.clear ? '0 : smp_in;
    end
    psum_r <= psum_in + SUM_W'(smp_r);
  end

  assign smp_out  = smp_r;
  assign psum_out = psum_r;

endmodule

// ----- rtl/wad_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of the window sum by the fill count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module wad_div
  import wad_pkg::*;
#(
  parameter int SUM_W = SAMPLE_BITS_DEF + 4,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  typedef enum logic {
    V_IDLE,
    V_RUN
  } div_state_t;

  div_state_t        state_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
    end else begin
      case (state_r)
        V_IDLE: begin
          if (start) begin
            q_r     <= dividend;
            den_r   <= divisor;
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= V_RUN;
          end
        end
        V_RUN: begin
          rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
          q_r    <= {q_r[SUM_W-2:0], ge};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_r <= V_IDLE;
          end
        end
        default: state_r <= V_IDLE;
      endcase
    end
  end

  assign busy     = (state_r != V_IDLE);
  assign quotient = q_r;

endmodule

// ----- rtl/wad_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance search
// Finds the largest distance d with (1000*d + 22448)^2 * sample within the
// squared range constant, one bit of d per pass of trial, square and check.
// ----------------------------------------------------------------------------
module wad_dist
  import wad_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   busy,
  output logic [DIST_BITS-1:0]   dist_mm
);

  localparam int PROD_W = DIST_SQ_W + SAMPLE_BITS;

  typedef enum logic [1:0] {
    D_IDLE,
    D_TRIAL,
    D_SQUARE,
    D_CHECK
  } dist_state_t;

  dist_state_t            state_r;
  logic [SAMPLE_BITS-1:0] v_r;
  logic [DIST_BITS-1:0]   d_r;
  logic [DIST_BITS-1:0]   bit_r;
  logic [DIST_A_W-1:0]    a_r;
  logic [DIST_SQ_W-1:0]   sq_r;
  logic [DIST_BITS-1:0]   t;
  logic [PROD_W-1:0]      prod;

  assign t    = d_r | bit_r;
  assign prod = PROD_W'(sq_r) * PROD_W'(v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            v_r     <= sample;
            d_r     <= '0;
            bit_r   <= {1'b1, {(DIST_BITS-1){1'b0}}};
            state_r <= D_TRIAL;
          end
        end
        D_TRIAL: begin
          a_r     <= DIST_A_W'(t) * DIST_SCALE + DIST_OFS;
          state_r <= D_SQUARE;
        end
        D_SQUARE: begin
          sq_r    <= DIST_SQ_W'(a_r) * DIST_SQ_W'(a_r);
          state_r <= D_CHECK;
        end
        D_CHECK: begin
          if (prod <= PROD_W'(DIST_LIMIT)) begin
            d_r <= t;
          end
          if (bit_r[0]) begin
            state_r <= D_IDLE;
          end else begin
            bit_r   <= bit_r >> 1;
            state_r <= D_TRIAL;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign busy    = (state_r != D_IDLE);
  assign dist_mm = d_r;

endmodule

// ----- rtl/windowed_average_distance_sensor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average distance sensor core
// Per sample: window mean, step change from the previous sample, channel,
// window start flag and a distance estimate in millimeters.
//
//   Channel   Ports                               Direction
//   in        in_valid, in_stall, in_sample       request in, stall out
//   out       out_valid, out_stall, out_channel,  request out, stall in
//             out_new_window, out_value, out_window_mean,
//             out_step_change, out_distance_mm, out_distance_invalid
//
// One request is in work at a time; the distance search, which settles one of
// its 11 bits per pass through its trial, square and check states, sets the
// time from acceptance to the output register. The input stall drops as the
// result is registered, so a new request is taken only after the last one is
// through. The mean path (through the cell row, then one divider step per sum
// bit) finishes earlier at default settings.
// Reset is synchronous and active low. A result held under out_stall does not
// block the next request; only a finished result waiting for a full output
// register stalls the block.
// ----------------------------------------------------------------------------
module windowed_average_distance_sensor_core
  import wad_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_BITS-1:0]   out_channel,
  output logic                   out_new_window,
  output logic [OUT_BITS-1:0]    out_value,
  output logic [OUT_BITS-1:0]    out_window_mean,
  output logic [OUT_BITS-1:0]    out_step_change,
  output logic [DIST_BITS-1:0]   out_distance_mm,
  output logic                   out_distance_invalid
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV
  } core_state_t;

  core_state_t            state_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       sum_cnt_r;
  logic [CH_W-1:0]        next_chan_r;
  logic [CH_W-1:0]        next_chan_nxt;
  logic [SAMPLE_BITS-1:0] prev_r;
  logic [SAMPLE_BITS-1:0] diff_nxt;

  logic [CH_W-1:0]        item_chan_r;
  logic                   item_fresh_r;
  logic [SAMPLE_BITS-1:0] item_value_r;
  logic [SAMPLE_BITS-1:0] item_diff_r;

  logic                   out_valid_r;
  logic [CHAN_BITS-1:0]   out_channel_r;
  logic                   out_new_window_r;
  logic [OUT_BITS-1:0]    out_value_r;
  logic [OUT_BITS-1:0]    out_window_mean_r;
  logic [OUT_BITS-1:0]    out_step_change_r;
  logic [DIST_BITS-1:0]   out_distance_mm_r;
  logic                   out_distance_invalid_r;

  logic                   accept;
  logic                   fresh;
  logic                   div_start;
  logic                   div_busy;
  logic                   dist_busy;
  logic                   out_free;
  logic                   finish;
  logic [SUM_W-1:0]       quotient;
  logic [DIST_BITS-1:0]   dist_mm;

  logic [CH_W+CHAN_BITS-1:0]       chan_ext;
  logic [SAMPLE_BITS+OUT_BITS-1:0] value_ext;
  logic [SAMPLE_BITS+OUT_BITS-1:0] diff_ext;
  logic [SUM_W+OUT_BITS-1:0]       mean_ext;

  wad_cell_ctl_t          cell_ctl [WINDOW];
  logic [SAMPLE_BITS-1:0] cell_smp [WINDOW];
  logic [SUM_W-1:0]       cell_sum [WINDOW];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign fresh     = (slot_r == '0);
  assign div_start = (state_r == S_SUM) && (sum_cnt_r == CNT_W'(WINDOW));
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == S_DIV) && !div_busy && !dist_busy && out_free;

  assign diff_nxt      = (prev_r > in_sample) ? prev_r - in_sample : in_sample - prev_r;
  assign next_chan_nxt = (next_chan_r == CH_W'(CHANNELS - 1)) ? '0 : next_chan_r + 1'b1;

  assign chan_ext  = {{CHAN_BITS{1'b0}}, item_chan_r};
  assign value_ext = {{OUT_BITS{1'b0}}, item_value_r};
  assign diff_ext  = {{OUT_BITS{1'b0}}, item_diff_r};
  assign mean_ext  = {{OUT_BITS{1'b0}}, quotient};

  genvar k;
  generate
    for (k = 0; k < WINDOW; k++) begin : g_cell
      assign cell_ctl[k].shift = accept;
      assign cell_ctl[k].clear = (k != 0) && fresh;

      wad_cell #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .SUM_W      (SUM_W)
      ) u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[k]),
        .smp_in  ((k == 0) ? in_sample : cell_smp[(k == 0) ? 0 : k - 1]),
        .psum_in ((k == 0) ? '0 : cell_sum[(k == 0) ? 0 : k - 1]),
        .smp_out (cell_smp[k]),
        .psum_out(cell_sum[k])
      );
    end
  endgenerate

  wad_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(cell_sum[WINDOW-1]),
    .divisor (count_r),
    .busy    (div_busy),
    .quotient(quotient)
  );

  wad_dist #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .sample (in_sample),
    .busy   (dist_busy),
    .dist_mm(dist_mm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      next_chan_r <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r      <= CNT_W'(slot_r) + 1'b1;
            slot_r       <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
            prev_r       <= in_sample;
            item_value_r <= in_sample;
            item_diff_r  <= diff_nxt;
            item_fresh_r <= fresh;
            sum_cnt_r    <= '0;
            if (fresh) begin
              item_chan_r <= next_chan_r;
              next_chan_r <= next_chan_nxt;
            end
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_cnt_r <= sum_cnt_r + 1'b1;
          if (div_start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (finish) begin
            out_valid_r            <= 1'b1;
            out_channel_r          <= chan_ext[CHAN_BITS-1:0];
            out_new_window_r       <= item_fresh_r;
            out_value_r            <= value_ext[OUT_BITS-1:0];
            out_window_mean_r      <= mean_ext[OUT_BITS-1:0];
            out_step_change_r      <= diff_ext[OUT_BITS-1:0];
            out_distance_invalid_r <= (item_value_r == '0);
            out_distance_mm_r      <= (item_value_r == '0) ? '0 : dist_mm;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel          = out_channel_r;
  assign out_new_window       = out_new_window_r;
  assign out_value            = out_value_r;
  assign out_window_mean      = out_window_mean_r;
  assign out_step_change      = out_step_change_r;
  assign out_distance_mm      = out_distance_mm_r;
  assign out_distance_invalid = out_distance_invalid_r;

endmodule

// ----- test/tb_windowed_average_distance_sensor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average distance sensor core testbench
// Sends converter samples through the request channel and checks every result
// against a cycle-free predictor of the window mean, step change, channel
// rotation and distance search, or against the typed rows of a short directed
// table for the extremes; random samples then run with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_windowed_average_distance_sensor_core;
  import wad_pkg::*;

  localparam int SBITS         = SAMPLE_BITS_DEF;
  localparam int WIN           = WINDOW_DEF;
  localparam int CHANS         = CHANNELS_DEF;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int DIRECTED_ROWS = 24;
  localparam int TAIL_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [CHAN_BITS-1:0] channel;
    logic                 new_window;
    logic [OUT_BITS-1:0]  value;
    logic [OUT_BITS-1:0]  window_mean;
    logic [OUT_BITS-1:0]  step_change;
    logic [DIST_BITS-1:0] distance_mm;
    logic                 distance_invalid;
  } reading_t;

  typedef struct packed {
    logic [SBITS-1:0] sample;
    logic             typed;
    reading_t         want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [SBITS-1:0]     in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAN_BITS-1:0] out_channel;
  logic                 out_new_window;
  logic [OUT_BITS-1:0]  out_value;
  logic [OUT_BITS-1:0]  out_window_mean;
  logic [OUT_BITS-1:0]  out_step_change;
  logic [DIST_BITS-1:0] out_distance_mm;
  logic                 out_distance_invalid;

  windowed_average_distance_sensor_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_channel          (out_channel),
    .out_new_window       (out_new_window),
    .out_value            (out_value),
    .out_window_mean      (out_window_mean),
    .out_step_change      (out_step_change),
    .out_distance_mm      (out_distance_mm),
    .out_distance_invalid (out_distance_invalid)
  );

  stim_row_t stim_rows [DIRECTED_ROWS] = '{
    '{12'd0,    1'b1, '{2'd0, 1'b1, 12'd0,    12'd0,    12'd0,    11'd0,    1'b1}},
    '{12'd4095, 1'b1, '{2'd0, 1'b0, 12'd4095, 12'd2047, 12'd4095, 11'd4,    1'b0}},
    '{12'd1,    1'b1, '{2'd0, 1'b0, 12'd1,    12'd1365, 12'd4094, 11'd1709, 1'b0}},
    '{12'd4095, 1'b1, '{2'd0, 1'b0, 12'd4095, 12'd2047, 12'd4094, 11'd4,    1'b0}},
    '{12'hAAA,  1'b0, '0},
    '{12'h555,  1'b0, '0},
    '{12'd100,  1'b0, '0},
    '{12'd4,    1'b0, '0},
    '{12'd2048, 1'b0, '0},
    '{12'd2047, 1'b0, '0},
    '{12'd0,    1'b1, '{2'd1, 1'b1, 12'd0,    12'd0,    12'd2047, 11'd0,    1'b1}},
    '{12'd0,    1'b1, '{2'd1, 1'b0, 12'd0,    12'd0,    12'd0,    11'd0,    1'b1}},
    '{12'd4095, 1'b0, '0},
    '{12'd1,    1'b0, '0},
    '{12'd2,    1'b0, '0},
    '{12'd3,    1'b0, '0},
    '{12'd4094, 1'b0, '0},
    '{12'h800,  1'b0, '0},
    '{12'h7FF,  1'b0, '0},
    '{12'd1,    1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd0,    1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd1,    1'b0, '0}
  };

  logic [SBITS-1:0] window_samples [WIN];
  int unsigned      window_slot;
  int unsigned      window_fill;
  int unsigned      channel_next;
  logic [SBITS-1:0] last_sample;

  reading_t    expected_readings [$];
  int          error_count;
  int          results_seen;
  int          cycle_count;
  int          stall_left;

  function automatic logic [DIST_BITS-1:0] search_distance(input logic [SBITS-1:0] v);
    logic [63:0]          bound;
    logic [63:0]          scaled;
    logic [DIST_BITS-1:0] best;
    logic [DIST_BITS-1:0] trial;
    bound = 64'd1732100 * 64'd1732100;
    best  = '0;
    for (int b = DIST_BITS - 1; b >= 0; b--) begin
      trial     = best;
      trial[b]  = 1'b1;
      scaled    = 64'(trial) * 64'd1000 + 64'd22448;
      if (scaled * scaled * 64'(v) <= bound) begin
        best = trial;
      end
    end
    if (64'd22448 * 64'd22448 * 64'(v) > bound) begin
      best = '0;
    end
    return best;
  endfunction

  function automatic reading_t predict_reading(input logic [SBITS-1:0] v);
    reading_t    r;
    int unsigned total;
    r = '0;
    if (window_slot == 0) begin
      for (int i = 0; i < WIN; i++) begin
        window_samples[i] = '0;
      end
      window_fill  = 0;
      channel_next = (channel_next + 1) % CHANS;
      r.new_window = 1'b1;
    end
    r.channel                   = CHAN_BITS'((channel_next + CHANS - 1) % CHANS);
    window_samples[window_slot] = v;
    window_slot                 = (window_slot + 1) % WIN;
    if (window_fill < WIN) begin
      window_fill++;
    end
    total = 0;
    for (int i = 0; i < window_fill; i++) begin
      total += window_samples[i];
    end
    r.window_mean = OUT_BITS'(total / window_fill);
    r.value       = v;
    r.step_change = (last_sample > v) ? last_sample - v : v - last_sample;
    last_sample   = v;
    if (v == 0) begin
      r.distance_invalid = 1'b1;
      r.distance_mm      = '0;
    end else begin
      r.distance_mm = search_distance(v);
    end
    return r;
  endfunction

  function automatic int draw_wait(input int n);
    if ((n / 80) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what,
               got, want);
    end
  endtask

  task automatic send_sample(input logic [SBITS-1:0] s, input int gap, input logic typed,
                             input reading_t want);
    reading_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predicted = predict_reading(s);
    expected_readings.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("windowed_average_distance_sensor_core regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (out_valid) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_channel, out_new_window, out_value, out_window_mean, out_step_change,
              out_distance_mm, out_distance_invalid};
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, count", 1, 0);
      end else begin
        want = expected_readings.pop_front();
        if (got.channel != want.channel)
          report_mismatch("channel", got.channel, want.channel);
        if (got.new_window != want.new_window)
          report_mismatch("new_window", got.new_window, want.new_window);
        if (got.value != want.value)
          report_mismatch("value", got.value, want.value);
        if (got.window_mean != want.window_mean)
          report_mismatch("window_mean", got.window_mean, want.window_mean);
        if (got.step_change != want.step_change)
          report_mismatch("step_change", got.step_change, want.step_change);
        if (got.distance_mm != want.distance_mm)
          report_mismatch("distance_mm", got.distance_mm, want.distance_mm);
        if (got.distance_invalid != want.distance_invalid)
          report_mismatch("distance_invalid", got.distance_invalid, want.distance_invalid);
      end
      results_seen++;
      stall_left <= draw_wait(results_seen);
    end
  end

  initial begin
    logic [SBITS-1:0] s;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    out_stall    = 1'b0;
    error_count  = 0;
    results_seen = 0;
    cycle_count  = 0;
    stall_left   = 0;
    for (int i = 0; i < WIN; i++) begin
      window_samples[i] = '0;
    end
    window_slot  = 0;
    window_fill  = 0;
    channel_next = 0;
    last_sample  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_sample(stim_rows[i].sample, (i < 12) ? 0 : draw_wait(i), stim_rows[i].typed,
                  stim_rows[i].want);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = '1;
        2:       s = SBITS'($urandom_range(1, 16));
        3:       s = SBITS'($urandom_range(4080, 4094));
        default: s = SBITS'($urandom_range(0, 4095));
      endcase
      send_sample(s, draw_wait(i), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("windowed_average_distance_sensor_core regression: pass");
    end else begin
      $display("windowed_average_distance_sensor_core regression: fail");
    end
    $finish;
  end

endmodule
